// File: sv/ssd_pkg.sv
`default_nettype none

package ssd_pkg;

    localparam int VALUE_W     = 16;
    localparam int LIMIT_W     = 14;
    localparam int NUM_W       = 14;
    localparam int WORD_W      = 16;
    localparam int BEAT_W      = 4;
    localparam int POS_W       = 2;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = 1;
    localparam int FIFO_CNT_W  = 2;

    localparam logic [LIMIT_W-1:0] MAX_LIMIT    = 14'd10000;
    localparam logic [7:0]         DASH_PATTERN = 8'hBF;
    localparam logic [7:0]         BLANK_PATTERN = 8'hFF;
    localparam logic [BEAT_W-1:0]  BEAT_LAST    = 4'd15;
    localparam logic [RECIP_W-1:0] RECIP_TEN    = 25'd1677722;

    localparam logic [FIFO_CNT_W-1:0] FIFO_FULL = 2'd2;

    typedef logic [WORD_W-1:0] ssd_word_t;

    // One frame request between the parts: segment byte over select byte
    typedef struct packed {
        logic      valid;
        ssd_word_t word;
    } ssd_req_t;

    // Active-low segment patterns for digits 0 to 9
    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        begin
            case (digit)
                4'd0:    pat = 8'hC0;
                4'd1:    pat = 8'hF9;
                4'd2:    pat = 8'hA4;
                4'd3:    pat = 8'hB0;
                4'd4:    pat = 8'h99;
                4'd5:    pat = 8'h92;
                4'd6:    pat = 8'h82;
                4'd7:    pat = 8'hF8;
                4'd8:    pat = 8'h80;
                4'd9:    pat = 8'h90;
                default: pat = BLANK_PATTERN;
            endcase
            return pat;
        end
    endfunction

    // Active-low digit select, thousands first
    function automatic logic [7:0] select_pattern(input logic [POS_W-1:0] pos);
        logic [7:0] pat;
        begin
            case (pos)
                2'd0:    pat = 8'hF7;
                2'd1:    pat = 8'hFB;
                2'd2:    pat = 8'hFD;
                2'd3:    pat = 8'hFE;
                default: pat = 8'hFF;
            endcase
            return pat;
        end
    endfunction

    // ceil(2^24 / place) for the place value of each scan position;
    // exact for every quotient below ten thousand
    function automatic logic [RECIP_W-1:0] place_recip(input logic [POS_W-1:0] pos);
        logic [RECIP_W-1:0] r;
        begin
            case (pos)
                2'd0:    r = 25'd16778;
                2'd1:    r = 25'd167773;
                2'd2:    r = 25'd1677722;
                2'd3:    r = 25'd16777216;
                default: r = 25'd16777216;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/ssd_front.sv
`default_nettype none

module ssd_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ssd_pkg::VALUE_W-1:0]   s_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [ssd_pkg::LIMIT_W-1:0]   cfg_wdata,
    output ssd_pkg::ssd_req_t                  push,
    input  wire logic                          push_ready
);
    import ssd_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic [POS_W-1:0]   pos_reg;

    logic               a_valid_reg;
    logic [NUM_W-1:0]   a_value_reg;
    logic               a_dash_reg;
    logic [POS_W-1:0]   a_pos_reg;

    logic               b_valid_reg;
    logic [NUM_W-1:0]   b_quot_reg;
    logic               b_dash_reg;
    logic [POS_W-1:0]   b_pos_reg;

    logic               c_valid_reg;
    ssd_word_t          c_word_reg;

    logic               a_ready, b_ready, c_ready, take;
    logic [LIMIT_W-1:0] eff_limit;
    logic               dash_in;
    logic [PROD_W-1:0]  prod_b, prod_c;
    logic [NUM_W-1:0]   quot_next, tens, tens_x10, rem;
    logic [7:0]         seg;
    ssd_word_t          word_next;

    assign c_ready  = !c_valid_reg || push_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;
    assign take     = s_tvalid && a_ready;

    // classify: clamp the limit so the thousands digit stays in the table
    assign eff_limit = (limit_reg > MAX_LIMIT) ? MAX_LIMIT : limit_reg;
    assign dash_in   = s_tdata >= {{(VALUE_W-LIMIT_W){1'b0}}, eff_limit};

    // divide by the place value
    assign prod_b    = {{RECIP_W{1'b0}}, a_value_reg} * {{NUM_W{1'b0}}, place_recip(a_pos_reg)};
    assign quot_next = prod_b[RECIP_SHIFT +: NUM_W];

    // take the quotient modulo ten
    assign prod_c    = {{RECIP_W{1'b0}}, b_quot_reg} * {{NUM_W{1'b0}}, RECIP_TEN};
    assign tens      = prod_c[RECIP_SHIFT +: NUM_W];
    assign tens_x10  = (tens << 3) + (tens << 1);
    assign rem       = b_quot_reg - tens_x10;
    assign seg       = b_dash_reg ? DASH_PATTERN : seg_pattern(rem[3:0]);
    assign word_next = {seg, select_pattern(b_pos_reg)};

    assign push.valid = c_valid_reg;
    assign push.word  = c_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= MAX_LIMIT;
            pos_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (take)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (a_ready)
            begin
                a_valid_reg <= s_tvalid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_value_reg <= s_tdata[NUM_W-1:0];
            a_dash_reg  <= dash_in;
            a_pos_reg   <= pos_reg;
        end
        if (b_ready && a_valid_reg)
        begin
            b_quot_reg <= quot_next;
            b_dash_reg <= a_dash_reg;
            b_pos_reg  <= a_pos_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            c_word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/ssd_fifo.sv
`default_nettype none

module ssd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  ssd_pkg::ssd_req_t  push,
    output logic               push_ready,
    output ssd_pkg::ssd_req_t  pop,
    input  wire logic          pop_ready
);
    import ssd_pkg::*;

    ssd_word_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign push_ready = count_reg != FIFO_FULL;
    assign pop.valid  = count_reg != '0;
    assign pop.word   = mem_reg[rd_ptr_reg];

    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop.valid && pop_ready;
    assign count_next = count_reg + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.word;
        end
    end

endmodule

`default_nettype wire

// File: sv/ssd_back.sv
`default_nettype none

module ssd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  ssd_pkg::ssd_req_t  pop,
    output logic               pop_ready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast
);
    import ssd_pkg::*;

    logic                busy_reg;
    logic [BEAT_W-1:0]   beat_reg;
    ssd_word_t           shift_reg;
    logic                last, take, load;

    assign last      = beat_reg == BEAT_LAST;
    assign take      = busy_reg && m_tready;
    assign pop_ready = !busy_reg || (take && last);
    assign load      = pop_ready && pop.valid;

    assign m_tvalid = busy_reg;
    assign m_tdata  = {7'b0, shift_reg[WORD_W-1]};
    assign m_tlast  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            beat_reg <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            beat_reg <= '0;
        end
        else if (take)
        begin
            busy_reg <= !last;
            beat_reg <= beat_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shift_reg <= pop.word;
        end
        else if (take)
        begin
            shift_reg <= {shift_reg[WORD_W-2:0], 1'b0};
        end
    end

endmodule

`default_nettype wire

// File: sv/seven_segment_scan_driver_core.sv
// Four-digit multiplexed seven-segment scan driver.
// Input channel (s_*): one request per scan tick carrying the 16-bit value to
// show. The block picks the decimal digit for the current scan position
// (thousands, hundreds, tens, units), maps it to an active-low segment
// pattern, or a dash when the value is at or above the overflow limit
// (clamped to 10000), then advances the position modulo four.
// Output channel (m_*): sixteen beats per request, one serial bit each in
// m_tdata[0]: segment byte then digit-select byte, MSB first. m_tlast marks
// the sixteenth bit; latch the external shift register after it.
// Configuration: cfg_we writes cfg_wdata into the overflow limit; write it
// only while no request is in flight.
// Path: an accepted request passes the three front stages and the queue
// before the serialiser loads it; the serialiser sets the request rate, and
// the front and a two-entry queue take further requests while it shifts.
// Reset: limit returns to 10000, scan position to the thousands digit, all
// pipeline and queue contents are dropped.
// Receiver stall: the current beat holds; the queue and the front stages fill
// and then s_tready drops until the serialiser moves on.
`default_nettype none

module seven_segment_scan_driver_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ssd_pkg::VALUE_W-1:0]   s_tdata,   // [15:0] display_value
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,   // [0] serial_bit, [7:1] zero
    output logic                               m_tlast,   // latch_pulse
    input  wire logic                          cfg_we,
    input  wire logic [ssd_pkg::LIMIT_W-1:0]   cfg_wdata  // overflow_limit
);
    import ssd_pkg::*;

    ssd_req_t push, pop;
    logic     push_ready, pop_ready;

    // classify the tick and build the 16-bit frame
    ssd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .push_ready (push_ready)
    );

    // decouple the front from the serialiser
    ssd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    // shift the frame out one bit per beat
    ssd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_ready (pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// File: sv/ssd_checker.sv
`default_nettype none

module ssd_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [7:0]                    m_tdata,
    input  wire logic                          m_tlast
);
    import ssd_pkg::*;

    localparam logic [3:0] MAX_PENDING = 4'd6;

    logic [BEAT_W-1:0] beat_reg;
    logic [POS_W-1:0]  fpos_reg;
    logic [3:0]        pending_reg;
    logic [7:0]        sel_byte;
    logic              in_take, out_take, frame_done;

    assign in_take    = s_tvalid && s_tready;
    assign out_take   = m_tvalid && m_tready;
    assign frame_done = out_take && m_tlast;
    assign sel_byte   = select_pattern(fpos_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg    <= '0;
            fpos_reg    <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (out_take)
            begin
                beat_reg <= beat_reg + 1'b1;
            end
            if (frame_done)
            begin
                fpos_reg <= fpos_reg + 1'b1;
            end
            pending_reg <= pending_reg + 4'(in_take) - 4'(frame_done);
        end
    end

    // hold a stalled beat
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled beat changed");

    // latch marks exactly the sixteenth bit of each frame
    a_latch_place: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (beat_reg == BEAT_LAST)))
        else $error("latch pulse out of place");

    // select byte follows the scan order
    a_select_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && beat_reg[3] |-> m_tdata[0] == sel_byte[~beat_reg[2:0]])
        else $error("digit select bit wrong");

    // no output without an outstanding request, no overrun of the buffering
    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid |-> pending_reg != 4'd0) and (pending_reg <= MAX_PENDING))
        else $error("request accounting broken");

endmodule

bind seven_segment_scan_driver_core ssd_checker u_checker (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // One expected beat on the serial channel
    typedef struct packed {
        logic data;
        logic last;
    } serial_beat_t;

    localparam int BEATS_PER_TICK = 16;
    localparam int MAX_IDLE       = 6;
    localparam int HOLD_OFF       = 300;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [ssd_pkg::VALUE_W-1:0]   s_tdata;     // [15:0] display_value
    logic                          m_tvalid;
    logic                          m_tready;
    logic [7:0]                    m_tdata;     // [0] serial_bit, [7:1] zero
    logic                          m_tlast;     // latch_pulse
    logic                          cfg_we;
    logic [ssd_pkg::LIMIT_W-1:0]   cfg_wdata;   // overflow_limit

    // Predictor state: a private copy of the limit register and the scan position
    logic [ssd_pkg::LIMIT_W-1:0]   limit_copy = ssd_pkg::MAX_LIMIT;
    logic [ssd_pkg::POS_W-1:0]     scan_pos   = '0;

    serial_beat_t                  pending_bits[$];
    int                            mismatch_count = 0;

    // Idling controls shared between the test tasks and the two sides
    bit                            tx_idle = 1'b1;
    bit                            rx_idle = 1'b1;
    int                            rx_hold = 0;

    seven_segment_scan_driver_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Active-low glyphs for the decimal digits
    function automatic logic [7:0] digit_glyph(input int unsigned digit);
        case (digit)
            0:       return 8'hC0;
            1:       return 8'hF9;
            2:       return 8'hA4;
            3:       return 8'hB0;
            4:       return 8'h99;
            5:       return 8'h92;
            6:       return 8'h82;
            7:       return 8'hF8;
            8:       return 8'h80;
            default: return 8'h90;
        endcase
    endfunction

    // Active-low digit enables, thousands first
    function automatic logic [7:0] digit_enable(input logic [ssd_pkg::POS_W-1:0] pos);
        case (pos)
            2'd0:    return 8'hF7;
            2'd1:    return 8'hFB;
            2'd2:    return 8'hFD;
            default: return 8'hFE;
        endcase
    endfunction

    function automatic int unsigned effective_limit();
        return (limit_copy > ssd_pkg::MAX_LIMIT) ? ssd_pkg::MAX_LIMIT : limit_copy;
    endfunction

    // Work out the sixteen beats for one accepted tick and advance the position
    task automatic predict_scan_tick(input logic [ssd_pkg::VALUE_W-1:0] value);
        int unsigned v;
        int unsigned digit;
        logic [7:0]  glyph;
        logic [15:0] frame;
        serial_beat_t beat;
        v = value;
        case (scan_pos)
            2'd0:    digit = (v / 1000) % 10;
            2'd1:    digit = (v / 100) % 10;
            2'd2:    digit = (v / 10) % 10;
            default: digit = v % 10;
        endcase
        // Overflow shows a dash on every position
        glyph = (v >= effective_limit()) ? ssd_pkg::DASH_PATTERN : digit_glyph(digit);
        frame = {glyph, digit_enable(scan_pos)};
        for (int k = 0; k < BEATS_PER_TICK; k++)
        begin
            beat.data = frame[BEATS_PER_TICK-1-k];
            beat.last = (k == BEATS_PER_TICK - 1);
            pending_bits.push_back(beat);
        end
        scan_pos = scan_pos + 1'b1;
    endtask

    // Offer one request, hold it until taken, then predict its beats.
    // Valid stays high across back-to-back requests.
    task automatic send_tick(input logic [ssd_pkg::VALUE_W-1:0] value);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        predict_scan_tick(value);
    endtask

    // Drop valid and wait until every predicted beat has been seen
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_bits.size() != 0)
            @(posedge clk);
    endtask

    // Write the overflow limit; only called with nothing in flight
    task automatic write_limit(input logic [ssd_pkg::LIMIT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_copy = value;
    endtask

    // Mostly in-range values, with values around the limit and full-width noise
    function automatic logic [ssd_pkg::VALUE_W-1:0] pick_value();
        int unsigned lim;
        int          sel;
        lim = effective_limit();
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3, 4: return $urandom_range(0, 9999);
            5, 6:          return $urandom_range(0, 65535);
            7:             return lim;
            8:             return (lim > 0) ? lim - 1 : 0;
            default:       return $urandom_range(10000, 65535);
        endcase
    endfunction

    // Reset value of the limit, digits at every position, field extremes
    task automatic test_default_limit();
        logic [15:0] values[$] = '{16'd0, 16'd9999, 16'd10000, 16'hFFFF, 16'd1234,
                                   16'd5678, 16'd9012, 16'd3456, 16'd7890};
        foreach (values[i])
            send_tick(values[i]);
        wait_idle();
    endtask

    // Limit of zero dashes everything; limits above ten thousand clamp; a limit of one dashes all but zero
    task automatic test_limit_extremes();
        write_limit('0);
        send_tick(16'd0);
        send_tick(16'd1);
        send_tick(16'd9999);
        send_tick(16'hFFFF);
        wait_idle();
        write_limit('1);
        send_tick(16'd9999);
        send_tick(16'd10000);
        send_tick(16'd12000);
        send_tick(16'd4321);
        wait_idle();
        write_limit(14'd1);
        send_tick(16'd0);
        send_tick(16'd1);
        send_tick(16'd0);
        send_tick(16'd2);
        wait_idle();
    endtask

    // Random values over a run of limit settings, extremes included
    task automatic test_random_ticks();
        logic [ssd_pkg::LIMIT_W-1:0] lim;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       lim = ssd_pkg::MAX_LIMIT;
                1:       lim = '0;
                2:       lim = '1;
                3:       lim = ssd_pkg::MAX_LIMIT - 1'b1;
                4, 5:    lim = $urandom_range(0, ssd_pkg::MAX_LIMIT);
                default: lim = $urandom_range(0, 16383);
            endcase
            write_limit(lim);
            // Leave phase 5 without idling so back-to-back traffic runs too
            tx_idle = (phase != 5);
            rx_idle = (phase != 5);
            repeat ($urandom_range(30, 45))
                send_tick(pick_value());
            wait_idle();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Hold the receiver off while requests keep coming, so the input stalls
    task automatic test_output_stall();
        write_limit(ssd_pkg::MAX_LIMIT);
        rx_hold = HOLD_OFF;
        tx_idle = 1'b0;
        repeat (24)
            send_tick(pick_value());
        tx_idle = 1'b1;
        wait_idle();
    endtask

    // Stream with no gaps on either side
    task automatic test_full_rate();
        write_limit($urandom_range(0, ssd_pkg::MAX_LIMIT));
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (40)
            send_tick(pick_value());
        wait_idle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Receiver: draw a stall per beat, or hold off for a long stretch on request
    initial
    begin
        int stall;
        int hold;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                hold    = rx_hold;
                rx_hold = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            stall = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Compare every accepted beat with the oldest prediction
    always @(posedge clk)
    begin
        serial_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_bits.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected beat, expected none, actual bit %b last %b",
                         $time, m_tdata[0], m_tlast);
            end
            else
            begin
                want = pending_bits.pop_front();
                if (m_tdata[0] !== want.data)
                begin
                    mismatch_count++;
                    $display("%0t: serial bit expected %b actual %b",
                             $time, want.data, m_tdata[0]);
                end
                if (m_tlast !== want.last)
                begin
                    mismatch_count++;
                    $display("%0t: latch pulse expected %b actual %b",
                             $time, want.last, m_tlast);
                end
            end
        end
    end

    initial
    begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_limit();
        test_limit_extremes();
        test_random_ticks();
        test_output_stall();
        test_full_rate();

        // Let any stray beats show before judging
        repeat (32) @(posedge clk);
        if (mismatch_count == 0 && pending_bits.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
